// File: sv/lzwd_pkg.sv
// lzwd_pkg: shared widths, constants and types for the LZ window decoder.
// Used by lzwd_take, lzwd_window and lz_window_decoder.
`default_nettype none

package lzwd_pkg;

    localparam int WINDOW_DEPTH_DEF = 65536;

    localparam int BYTE_W   = 8;
    localparam int BITS_W   = 24;
    localparam int CNT_W    = 5;
    localparam int POS_W    = 16;
    localparam int LEN_W    = 4;
    localparam int FLAG_W   = 1;
    localparam int LEN_BIAS = 3;
    localparam int COPY_W   = 5;

    typedef struct packed {
        logic [POS_W-1:0]  val;
        logic [BITS_W-1:0] rest;
        logic [CNT_W-1:0]  left;
    } take_t;

endpackage

`default_nettype wire

// File: sv/lzwd_take.sv
// lzwd_take: shared bit extraction unit, takes the top n bits of the bit buffer.
// Depends on lzwd_pkg.
`default_nettype none

module lzwd_take (
    input  wire logic [lzwd_pkg::BITS_W-1:0] bits_i,
    input  wire logic [lzwd_pkg::CNT_W-1:0]  cnt_i,
    input  wire logic [lzwd_pkg::CNT_W-1:0]  need_i,
    output lzwd_pkg::take_t                  tk_o
);

    logic [lzwd_pkg::CNT_W-1:0]  left;
    logic [lzwd_pkg::BITS_W-1:0] shifted;
    logic [lzwd_pkg::BITS_W-1:0] vmask;
    logic [lzwd_pkg::BITS_W-1:0] kmask;

    always_comb begin
        left       = cnt_i - need_i;
        shifted    = bits_i >> left;
        vmask      = (lzwd_pkg::BITS_W'(1) << need_i) - lzwd_pkg::BITS_W'(1);
        kmask      = (lzwd_pkg::BITS_W'(1) << left) - lzwd_pkg::BITS_W'(1);
        tk_o.val   = lzwd_pkg::POS_W'(shifted & vmask);
        tk_o.rest  = bits_i & kmask;
        tk_o.left  = left;
    end

endmodule

`default_nettype wire

// File: sv/lzwd_window.sv
// lzwd_window: history window memory with write pointer and fill count.
// Entries not written since the stream start read as zero. Depends on lzwd_pkg.
`default_nettype none

module lzwd_window #(
    parameter int WINDOW_DEPTH = lzwd_pkg::WINDOW_DEPTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          clr,
    input  wire logic                          rd_en,
    input  wire logic [$clog2(WINDOW_DEPTH)-1:0] rd_addr,
    output logic      [lzwd_pkg::BYTE_W-1:0]   rd_data,
    input  wire logic                          wr_en,
    input  wire logic [lzwd_pkg::BYTE_W-1:0]   wr_data
);

    localparam int AW = $clog2(WINDOW_DEPTH);

    logic [lzwd_pkg::BYTE_W-1:0] mem [WINDOW_DEPTH];
    logic [lzwd_pkg::BYTE_W-1:0] data_reg;
    logic                        hit_reg;
    logic [AW-1:0]               wptr_reg, wptr_next;
    logic [AW:0]                 fill_reg, fill_next;
    logic [AW-1:0]               rel;
    logic                        hit;

    always_comb begin
        rel = rd_addr - AW'(1);
        hit = ({1'b0, rel} < fill_reg);
    end

    always_comb begin
        wptr_next = wptr_reg;
        fill_next = fill_reg;
        if (clr) begin
            wptr_next = AW'(1);
            fill_next = '0;
        end else if (wr_en) begin
            wptr_next = wptr_reg + AW'(1);
            if (fill_reg != (AW+1)'(WINDOW_DEPTH)) begin
                fill_next = fill_reg + (AW+1)'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= AW'(1);
            fill_reg <= '0;
        end else begin
            wptr_reg <= wptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            data_reg <= mem[rd_addr];
            hit_reg  <= hit;
        end
        if (wr_en) begin
            mem[wptr_reg] <= wr_data;
        end
    end

    assign rd_data = hit_reg ? data_reg : '0;

endmodule

`default_nettype wire

// File: sv/lz_window_decoder.sv
// lz_window_decoder: LZSS decoder with 64K window, one compressed byte per input beat.
// Each token field is taken in its own parse step; a copied byte is a window read,
// then a write. Bytes are taken only in idle; after an end marker, dropped till in_last.
// Reset: control state clears synchronously; no memory clearing pass, stale window
// entries are masked by a fill count, also at each new stream after in_last.
// Depends on lzwd_pkg, lzwd_take, lzwd_window.
`default_nettype none

module lz_window_decoder #(
    parameter int WINDOW_DEPTH = lzwd_pkg::WINDOW_DEPTH_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [lzwd_pkg::BYTE_W-1:0] s_in_byte,
    input  wire logic                        s_in_last,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic      [lzwd_pkg::BYTE_W-1:0] m_out_byte,
    output logic                             m_run_last,
    output logic                             m_done_res,
    output logic                             m_error
);

    localparam int AW = $clog2(WINDOW_DEPTH);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PARSE = 3'd1;
    localparam logic [2:0] ST_RD    = 3'd2;
    localparam logic [2:0] ST_DATA  = 3'd3;
    localparam logic [2:0] ST_END   = 3'd4;

    localparam logic [1:0] PH_FLAG = 2'd0;
    localparam logic [1:0] PH_LIT  = 2'd1;
    localparam logic [1:0] PH_POS  = 2'd2;
    localparam logic [1:0] PH_LEN  = 2'd3;

    logic [2:0]                    state_reg, state_next;
    logic [1:0]                    phase_reg, phase_next;
    logic [lzwd_pkg::BITS_W-1:0]   bits_reg, bits_next;
    logic [lzwd_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [lzwd_pkg::POS_W-1:0]    match_reg, match_next;
    logic [lzwd_pkg::COPY_W-1:0]   len_reg, len_next;
    logic [lzwd_pkg::COPY_W-1:0]   idx_reg, idx_next;
    logic                          last_reg, last_next;
    logic                          fin_reg, fin_next;

    logic                          mv_reg, mv_next;
    logic [lzwd_pkg::BYTE_W-1:0]   byte_reg, byte_next;
    logic                          rl_reg, rl_next;
    logic                          done_reg, done_next;
    logic                          err_reg, err_next;

    logic [lzwd_pkg::CNT_W-1:0]    need;
    logic                          enough;
    logic                          out_free;
    lzwd_pkg::take_t               tk;

    logic                          win_clr;
    logic                          win_rd_en;
    logic                          win_wr_en;
    logic [lzwd_pkg::POS_W-1:0]    rd_pos;
    logic [lzwd_pkg::BYTE_W-1:0]   win_rd_data;

    lzwd_take u_take (
        .bits_i (bits_reg),
        .cnt_i  (cnt_reg),
        .need_i (need),
        .tk_o   (tk)
    );

    assign rd_pos = match_reg + lzwd_pkg::POS_W'(idx_reg);

    lzwd_window #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clr     (win_clr),
        .rd_en   (win_rd_en),
        .rd_addr (rd_pos[AW-1:0]),
        .rd_data (win_rd_data),
        .wr_en   (win_wr_en),
        .wr_data (byte_next)
    );

    always_comb begin
        unique case (phase_reg)
            PH_FLAG: need = lzwd_pkg::CNT_W'(lzwd_pkg::FLAG_W);
            PH_LIT:  need = lzwd_pkg::CNT_W'(lzwd_pkg::BYTE_W);
            PH_POS:  need = lzwd_pkg::CNT_W'(lzwd_pkg::POS_W);
            PH_LEN:  need = lzwd_pkg::CNT_W'(lzwd_pkg::LEN_W);
            default: need = lzwd_pkg::CNT_W'(lzwd_pkg::FLAG_W);
        endcase
    end

    assign enough   = (cnt_reg >= need);
    assign out_free = !mv_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        bits_next  = bits_reg;
        cnt_next   = cnt_reg;
        match_next = match_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        last_next  = last_reg;
        fin_next   = fin_reg;
        mv_next    = mv_reg && !m_ready;
        byte_next  = byte_reg;
        rl_next    = rl_reg;
        done_next  = done_reg;
        err_next   = err_reg;
        win_clr    = 1'b0;
        win_rd_en  = 1'b0;
        win_wr_en  = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (fin_reg) begin
                        if (s_in_last) begin
                            win_clr = 1'b1;
                        end
                    end else begin
                        bits_next  = {bits_reg[lzwd_pkg::BITS_W-lzwd_pkg::BYTE_W-1:0],
                                      s_in_byte};
                        cnt_next   = cnt_reg + lzwd_pkg::CNT_W'(lzwd_pkg::BYTE_W);
                        last_next  = s_in_last;
                        state_next = ST_PARSE;
                    end
                end
            end
            ST_PARSE: begin
                if (!enough) begin
                    state_next = ST_END;
                end else begin
                    unique case (phase_reg)
                        PH_FLAG: begin
                            bits_next  = tk.rest;
                            cnt_next   = tk.left;
                            phase_next = tk.val[0] ? PH_LIT : PH_POS;
                        end
                        PH_LIT: begin
                            if (out_free) begin
                                bits_next  = tk.rest;
                                cnt_next   = tk.left;
                                phase_next = PH_FLAG;
                                mv_next    = 1'b1;
                                byte_next  = tk.val[lzwd_pkg::BYTE_W-1:0];
                                rl_next    = !last_reg;
                                done_next  = 1'b0;
                                err_next   = 1'b0;
                                win_wr_en  = 1'b1;
                            end
                        end
                        PH_POS: begin
                            if (tk.val == '0) begin
                                if (out_free) begin
                                    bits_next  = '0;
                                    cnt_next   = '0;
                                    phase_next = PH_FLAG;
                                    fin_next   = 1'b1;
                                    mv_next    = 1'b1;
                                    byte_next  = '0;
                                    rl_next    = 1'b1;
                                    done_next  = 1'b1;
                                    err_next   = 1'b0;
                                    state_next = ST_END;
                                end
                            end else begin
                                bits_next  = tk.rest;
                                cnt_next   = tk.left;
                                match_next = tk.val;
                                phase_next = PH_LEN;
                            end
                        end
                        PH_LEN: begin
                            bits_next  = tk.rest;
                            cnt_next   = tk.left;
                            len_next   = lzwd_pkg::COPY_W'(tk.val[lzwd_pkg::LEN_W-1:0])
                                       + lzwd_pkg::COPY_W'(lzwd_pkg::LEN_BIAS);
                            idx_next   = '0;
                            phase_next = PH_FLAG;
                            state_next = ST_RD;
                        end
                        default: state_next = ST_END;
                    endcase
                end
            end
            ST_RD: begin
                win_rd_en  = 1'b1;
                state_next = ST_DATA;
            end
            ST_DATA: begin
                if (out_free) begin
                    mv_next   = 1'b1;
                    byte_next = win_rd_data;
                    rl_next   = (idx_reg == len_reg - lzwd_pkg::COPY_W'(1)) && !last_reg;
                    done_next = 1'b0;
                    err_next  = 1'b0;
                    win_wr_en = 1'b1;
                    idx_next  = idx_reg + lzwd_pkg::COPY_W'(1);
                    if (idx_reg == len_reg - lzwd_pkg::COPY_W'(1)) begin
                        state_next = ST_PARSE;
                    end else begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_END: begin
                if (!last_reg) begin
                    state_next = ST_IDLE;
                end else if (fin_reg) begin
                    win_clr    = 1'b1;
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    mv_next    = 1'b1;
                    byte_next  = '0;
                    rl_next    = 1'b1;
                    done_next  = 1'b0;
                    err_next   = 1'b1;
                    win_clr    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (win_clr) begin
            bits_next  = '0;
            cnt_next   = '0;
            phase_next = PH_FLAG;
            match_next = '0;
            fin_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_FLAG;
            bits_reg  <= '0;
            cnt_reg   <= '0;
            match_reg <= '0;
            fin_reg   <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            bits_reg  <= bits_next;
            cnt_reg   <= cnt_next;
            match_reg <= match_next;
            fin_reg   <= fin_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg  <= len_next;
        idx_reg  <= idx_next;
        last_reg <= last_next;
        byte_reg <= byte_next;
        rl_reg   <= rl_next;
        done_reg <= done_next;
        err_reg  <= err_next;
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = mv_reg;
    assign m_out_byte = byte_reg;
    assign m_run_last = rl_reg;
    assign m_done_res = done_reg;
    assign m_error    = err_reg;

endmodule

`default_nettype wire

// File: sim/lz_window_decoder_checker.sv
// lz_window_decoder_checker: watches both channels of the LZ window decoder, predicts the
// decoded beats for each compressed byte taken and compares them in order.
// Depends on lzwd_pkg for field widths and token constants.

module lz_window_decoder_checker (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    input  wire logic                  s_ready,
    input  wire logic [lzwd_pkg::BYTE_W-1:0] s_in_byte,
    input  wire logic                  s_in_last,
    input  wire logic                  m_valid,
    input  wire logic                  m_ready,
    input  wire logic [lzwd_pkg::BYTE_W-1:0] m_out_byte,
    input  wire logic                  m_run_last,
    input  wire logic                  m_done_res,
    input  wire logic                  m_error,
    output int                         n_fail,
    output int                         n_pending,
    output int                         n_results,
    output int                         n_streams
);
    import lzwd_pkg::*;

    typedef enum logic [1:0] {TOK_FLAG, TOK_LIT, TOK_POS, TOK_LEN} tok_phase_e;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              run_last;
        logic              done_res;
        logic              error;
    } dec_beat_t;

    dec_beat_t        decoded_q[$];
    dec_beat_t        beat_q[$];
    bit [BYTE_W-1:0]  win_mem [bit [POS_W-1:0]];
    logic [POS_W-1:0] wr_ptr;
    logic [POS_W-1:0] match_pos;
    logic [31:0]      bit_acc;
    int unsigned      bit_cnt;
    tok_phase_e       tok_phase;
    bit               stream_done;

    function automatic void restart_stream();
        win_mem.delete();
        wr_ptr      = 16'd1;
        bit_acc     = '0;
        bit_cnt     = 0;
        tok_phase   = TOK_FLAG;
        match_pos   = '0;
        stream_done = 1'b0;
    endfunction

    function automatic logic [31:0] pull_bits(input int unsigned n);
        logic [31:0] v;
        v       = (bit_acc >> (bit_cnt - n)) & ((32'd1 << n) - 32'd1);
        bit_cnt = bit_cnt - n;
        bit_acc = bit_acc & ((32'd1 << bit_cnt) - 32'd1);
        return v;
    endfunction

    function automatic void put_byte(input logic [BYTE_W-1:0] b);
        win_mem[wr_ptr] = b;
        wr_ptr          = wr_ptr + 16'd1;
        beat_q.push_back('{data: b, run_last: 1'b0, done_res: 1'b0, error: 1'b0});
    endfunction

    function automatic void decode_beat(input logic [BYTE_W-1:0] b, input logic last);
        bit               more;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] rd;
        int unsigned      len;
        beat_q.delete();
        if (!stream_done) begin
            bit_acc = (bit_acc << BYTE_W) | 32'(b);
            bit_cnt = bit_cnt + BYTE_W;
            more    = 1'b1;
            while (more) begin
                case (tok_phase)
                    TOK_FLAG: begin
                        if (bit_cnt < FLAG_W) more = 1'b0;
                        else tok_phase = (pull_bits(FLAG_W) != 0) ? TOK_LIT : TOK_POS;
                    end
                    TOK_LIT: begin
                        if (bit_cnt < BYTE_W) more = 1'b0;
                        else begin
                            put_byte(BYTE_W'(pull_bits(BYTE_W)));
                            tok_phase = TOK_FLAG;
                        end
                    end
                    TOK_POS: begin
                        if (bit_cnt < POS_W) more = 1'b0;
                        else begin
                            pos = POS_W'(pull_bits(POS_W));
                            if (pos == 0) begin
                                // end marker: rest of this byte is dropped
                                stream_done = 1'b1;
                                bit_acc     = '0;
                                bit_cnt     = 0;
                                tok_phase   = TOK_FLAG;
                                beat_q.push_back('{data: '0, run_last: 1'b0,
                                                   done_res: 1'b1, error: 1'b0});
                                more        = 1'b0;
                            end else begin
                                match_pos = pos;
                                tok_phase = TOK_LEN;
                            end
                        end
                    end
                    default: begin
                        if (bit_cnt < LEN_W) more = 1'b0;
                        else begin
                            len = pull_bits(LEN_W) + LEN_BIAS;
                            for (int i = 0; i < len; i++) begin
                                rd = match_pos + POS_W'(i);
                                put_byte(win_mem.exists(rd) ? win_mem[rd] : '0);
                            end
                            tok_phase = TOK_FLAG;
                        end
                    end
                endcase
            end
        end
        if (last) begin
            if (!stream_done)
                beat_q.push_back('{data: '0, run_last: 1'b0, done_res: 1'b0, error: 1'b1});
            restart_stream();
        end
        if (beat_q.size() > 0) beat_q[beat_q.size() - 1].run_last = 1'b1;
        foreach (beat_q[i]) decoded_q.push_back(beat_q[i]);
    endfunction

    task automatic report_mismatch(input string what, input dec_beat_t want,
                                   input dec_beat_t got);
        n_fail++;
        if (n_fail <= 20)
            $display("MISMATCH (%s): got byte=%02h last=%0b done=%0b err=%0b, want byte=%02h last=%0b done=%0b err=%0b",
                     what, got.data, got.run_last, got.done_res, got.error,
                     want.data, want.run_last, want.done_res, want.error);
    endtask

    always @(posedge aclk) begin
        dec_beat_t got;
        dec_beat_t want;
        if (!aresetn) begin
            restart_stream();
            decoded_q.delete();
            n_pending <= 0;
        end else begin
            if (m_valid && m_ready) begin
                got = '{data: m_out_byte, run_last: m_run_last,
                        done_res: m_done_res, error: m_error};
                n_results++;
                if (decoded_q.size() == 0) report_mismatch("unexpected beat", '0, got);
                else begin
                    want = decoded_q.pop_front();
                    if (got.data !== want.data) report_mismatch("out_byte", want, got);
                    else if (got.run_last !== want.run_last)
                        report_mismatch("run_last", want, got);
                    else if (got.done_res !== want.done_res)
                        report_mismatch("done_res", want, got);
                    else if (got.error !== want.error) report_mismatch("error", want, got);
                end
            end
            if (s_valid && s_ready) begin
                decode_beat(s_in_byte, s_in_last);
                if (s_in_last) n_streams++;
            end
            n_pending <= decoded_q.size();
        end
    end

endmodule

// File: sim/lz_window_decoder_tb.sv
// lz_window_decoder_tb: drives compressed streams into the LZ window decoder with random
// gaps and back-pressure; the checker alongside does the prediction and comparison.
// Depends on lzwd_pkg, lz_window_decoder and lz_window_decoder_checker.

module lz_window_decoder_tb;
    import lzwd_pkg::*;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid;
    logic              s_ready;
    logic [BYTE_W-1:0] s_in_byte;
    logic              s_in_last;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [BYTE_W-1:0] m_out_byte;
    logic              m_run_last;
    logic              m_done_res;
    logic              m_error;

    int n_fail;
    int n_pending;
    int n_results;
    int n_streams;

    bit               pend_bits[$];
    logic [BYTE_W-1:0] code_bytes[$];
    logic [POS_W-1:0] gen_wr = 16'd1;
    int               items_sent = 0;
    bit               calm = 1'b0;
    int               sink_hold = 0;

    lz_window_decoder u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .s_in_last  (s_in_last),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_run_last (m_run_last),
        .m_done_res (m_done_res),
        .m_error    (m_error)
    );

    lz_window_decoder_checker u_chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .s_in_last  (s_in_last),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_run_last (m_run_last),
        .m_done_res (m_done_res),
        .m_error    (m_error),
        .n_fail     (n_fail),
        .n_pending  (n_pending),
        .n_results  (n_results),
        .n_streams  (n_streams)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // sink: alternating ready bursts and stalls
    always @(posedge aclk) begin
        int g;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            sink_hold <= 0;
        end else if (calm) begin
            m_ready <= 1'b1;
        end else if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
        end else if (m_ready) begin
            g = gap_len();
            m_ready   <= (g == 0);
            sink_hold <= g;
        end else begin
            m_ready   <= 1'b1;
            sink_hold <= $urandom_range(0, 12);
        end
    end

    function automatic void push_field(input logic [31:0] v, input int n);
        for (int i = n - 1; i >= 0; i--) pend_bits.push_back(v[i]);
    endfunction

    function automatic void add_lit(input logic [BYTE_W-1:0] b);
        push_field(1, FLAG_W);
        push_field(32'(b), BYTE_W);
        gen_wr = gen_wr + 16'd1;
    endfunction

    function automatic void add_match(input logic [POS_W-1:0] pos, input logic [LEN_W-1:0] len);
        push_field(0, FLAG_W);
        push_field(32'(pos), POS_W);
        push_field(32'(len), LEN_W);
        gen_wr = gen_wr + POS_W'(len) + POS_W'(LEN_BIAS);
    endfunction

    function automatic void add_end();
        push_field(0, FLAG_W + POS_W);
    endfunction

    // mostly positions inside what has been written, some overlapping, some anywhere
    function automatic logic [POS_W-1:0] pick_pos();
        logic [POS_W-1:0] span;
        logic [POS_W-1:0] p;
        span = gen_wr - 16'd1;
        case ($urandom_range(0, 9))
            0:       p = POS_W'($urandom_range(1, 65535));
            1, 2:    p = gen_wr - POS_W'($urandom_range(1, 3));
            default: p = (span == 0) ? 16'd1 : POS_W'($urandom_range(1, span));
        endcase
        if (p == 0) p = 16'd1;
        return p;
    endfunction

    task automatic send_beat(input logic [BYTE_W-1:0] b, input logic last);
        int g;
        g = calm ? 0 : gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        s_in_last <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // pads the bit stream to whole bytes, optionally cuts it short, appends ignored junk
    task automatic send_stream(input int junk, input int keep);
        logic [BYTE_W-1:0] b;
        int n;
        while (pend_bits.size() % BYTE_W != 0) pend_bits.push_back(1'($urandom_range(0, 1)));
        while (pend_bits.size() != 0) begin
            for (int j = 0; j < BYTE_W; j++) b = {b[BYTE_W-2:0], pend_bits.pop_front()};
            code_bytes.push_back(b);
        end
        if (keep > 0) while (code_bytes.size() > keep) void'(code_bytes.pop_back());
        items_sent += code_bytes.size();
        repeat (junk) code_bytes.push_back(BYTE_W'($urandom));
        n = code_bytes.size();
        for (int i = 0; i < n; i++) send_beat(code_bytes[i], i == n - 1);
        code_bytes.delete();
        gen_wr = 16'd1;
    endtask

    initial begin
        int kind;
        int ntok;
        s_valid   <= 1'b0;
        s_in_byte <= '0;
        s_in_last <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // extreme literals, overlapping copy, read wrap, end marker then junk
        add_lit(8'h00);
        add_lit(8'hFF);
        add_match(16'd1, 4'd0);
        add_match(16'hFFFF, 4'd15);
        add_lit(8'hA5);
        add_end();
        send_stream(2, 0);
        // single-byte streams cut mid-token
        push_field(0, BYTE_W);
        send_stream(0, 0);
        push_field(32'hFF, BYTE_W);
        send_stream(0, 0);
        // end marker alone, closing on the last byte
        add_end();
        send_stream(0, 0);
        // longest copy finishing on a last byte with no end marker
        repeat (3) add_lit(BYTE_W'($urandom));
        add_match(16'd2, 4'd15);
        send_stream(0, 0);

        while (items_sent < 220) begin
            kind = $urandom_range(0, 19);
            calm = ($urandom_range(0, 7) == 0);
            ntok = $urandom_range(1, 8);
            if (kind < 17) begin
                repeat (ntok) begin
                    if ($urandom_range(0, 1) != 0) add_lit(BYTE_W'($urandom));
                    else add_match(pick_pos(), LEN_W'($urandom_range(0, 15)));
                end
            end
            if (kind < 14) begin
                add_end();
                send_stream($urandom_range(0, 2), 0);
            end else if (kind < 17) begin
                send_stream(0, $urandom_range(1, (pend_bits.size() + 7) / 8));
            end else begin
                repeat ($urandom_range(1, 5)) push_field($urandom, BYTE_W);
                send_stream(0, 0);
            end
        end
        calm = 1'b0;
        s_valid <= 1'b0;

        @(posedge aclk);
        while (n_pending != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);

        $display("Run covered %0d streams and %0d decoded beats, incl. read position wrap,",
                 n_streams, n_results);
        $display("end markers, cut-off streams, junk after the end and random noise.");
        if (n_fail == 0 && n_pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
